[sv/symmetric_3x3_filter_core_defines.svh]
// assertion macros for the symmetric 3x3 filter
`ifndef SYMMETRIC_3X3_FILTER_CORE_DEFINES_SVH
`define SYMMETRIC_3X3_FILTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define S3F_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("s3f check failed");

// next-cycle implication
`define S3F_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("s3f check failed");

`endif

[sv/s3f_pkg.sv]
package s3f_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int COORD_W    = 10;
	localparam int VALUE_W    = 24;
	localparam int OUT_DATA_W = 48;
	localparam int SIZE_W     = 11;
	localparam int WEIGHT_W   = 12;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd1024;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd1024;
	localparam logic signed [WEIGHT_W-1:0] CENTER_RST = 12'sd256;
	localparam logic signed [WEIGHT_W-1:0] EDGE_RST   = 12'sd0;
	localparam logic signed [WEIGHT_W-1:0] CORNER_RST = 12'sd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_CENTER_WEIGHT = 3'd2,
		REG_EDGE_WEIGHT   = 3'd3,
		REG_CORNER_WEIGHT = 3'd4
	} reg_idx_t;

	typedef logic [2:0][2:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic [PIX_W-1:0] ctr;
		logic [9:0]       edg;
		logic [9:0]       crn;
	} cls_sum_t;

	typedef struct packed {
		cls_sum_t             sums;
		logic [COORD_W-1:0]   row;
		logic [COORD_W-1:0]   col;
		logic                 eof;
	} desc_t;

	typedef struct packed {
		desc_t desc;
		logic  last;
	} job_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [COORD_W-1:0]        row;
		logic [COORD_W-1:0]        col;
		logic                      last;
		logic                      eof;
	} res_t;

	// per-class pixel sums around window cell (cr, cc); flags say which sides are in frame
	function automatic cls_sum_t win_sums(win_t w, int cr, int cc,
		logic up, logic dn, logic lf, logic rt);
		cls_sum_t s;
		int dr;
		int dc;
		int ri;
		int ci;
		logic on;
		s = '0;
		for (dr = -1; dr <= 1; dr++) begin
			for (dc = -1; dc <= 1; dc++) begin
				on = !((dr < 0 && !up) || (dr > 0 && !dn) || (dc < 0 && !lf) || (dc > 0 && !rt));
				ri = cr + dr;
				ci = cc + dc;
				if (on && ri >= 0 && ri <= 2 && ci >= 0 && ci <= 2) begin
					if (dr == 0 && dc == 0) begin
						s.ctr = w[2'(ri)][2'(ci)];
					end else if (dr == 0 || dc == 0) begin
						s.edg = s.edg + 10'(w[2'(ri)][2'(ci)]);
					end else begin
						s.crn = s.crn + 10'(w[2'(ri)][2'(ci)]);
					end
				end
			end
		end
		return s;
	endfunction

endpackage

[sv/s3f_linebuf.sv]
module s3f_linebuf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;
	logic [DW-1:0] fwd_data_q;
	logic          fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// read of the entry being written in the same cycle takes the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

[sv/s3f_mac.sv]
module s3f_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  s3f_pkg::job_t                          in_job,
	input  logic signed [s3f_pkg::WEIGHT_W-1:0]    center_weight,
	input  logic signed [s3f_pkg::WEIGHT_W-1:0]    edge_weight,
	input  logic signed [s3f_pkg::WEIGHT_W-1:0]    corner_weight,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output s3f_pkg::res_t                          out_res
);

	logic                 v_s1;
	logic                 v_s2;
	logic signed [20:0]   pc_s1;
	logic signed [22:0]   pe_s1;
	logic signed [22:0]   pk_s1;
	s3f_pkg::job_t        job_s1;
	s3f_pkg::res_t        res_s2;
	logic                 adv_s2;
	logic                 adv_s1;

	assign adv_s2   = !v_s2 || out_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			pc_s1  <= 21'($signed({1'b0, in_job.desc.sums.ctr})) * 21'(center_weight);
			pe_s1  <= 23'($signed({1'b0, in_job.desc.sums.edg})) * 23'(edge_weight);
			pk_s1  <= 23'($signed({1'b0, in_job.desc.sums.crn})) * 23'(corner_weight);
			job_s1 <= in_job;
		end
		if (adv_s2 && v_s1) begin
			res_s2.value <= 24'(pc_s1) + 24'(pe_s1) + 24'(pk_s1);
			res_s2.row   <= job_s1.desc.row;
			res_s2.col   <= job_s1.desc.col;
			res_s2.last  <= job_s1.last;
			res_s2.eof   <= job_s1.desc.eof;
		end
	end

	assign out_valid = v_s2;
	assign out_res   = res_s2;

endmodule

[sv/symmetric_3x3_filter_core.sv]
// pipeline: input stage, window/result queue, MAC product register, MAC sum register
// throughput: one pixel per cycle unless stalled by m_tready; results leave one beat
// per cycle via a single three-multiplier unit, so a multi-result pixel holds the input
// line buffers: one dual-port memory of two rows, read and written once per pixel
// reset: config returns to its defaults; counters, window and pipeline valids clear;
// the line memory is not cleared and needs no clearing pass
module symmetric_3x3_filter_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [s3f_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [s3f_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // pixel
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [s3f_pkg::OUT_DATA_W-1:0]    m_tdata,  // filtered_value, out_row, out_col
	output logic                              m_tlast,  // last_of_run
	output logic                              m_tuser   // end_of_frame
);

	localparam int CW  = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;
	localparam int RW  = ($clog2(MAX_HEIGHT) > 2) ? $clog2(MAX_HEIGHT) : 2;
	localparam int WXW = (CW + 1 > s3f_pkg::SIZE_W) ? CW + 1 : s3f_pkg::SIZE_W;
	localparam int HXW = (RW + 1 > s3f_pkg::SIZE_W) ? RW + 1 : s3f_pkg::SIZE_W;
	localparam int PW  = s3f_pkg::PIX_W;

	logic [s3f_pkg::SIZE_W-1:0]            width_q;
	logic [s3f_pkg::SIZE_W-1:0]            height_q;
	logic signed [s3f_pkg::WEIGHT_W-1:0]   center_q;
	logic signed [s3f_pkg::WEIGHT_W-1:0]   edge_q;
	logic signed [s3f_pkg::WEIGHT_W-1:0]   corner_q;

	logic [WXW-1:0] w_ext;
	logic [WXW-1:0] w_eff;
	logic [HXW-1:0] h_ext;
	logic [HXW-1:0] h_eff;
	logic [CW-1:0]  w_last;
	logic [RW-1:0]  h_last;

	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic           last_col;
	logic           last_row;
	logic [CW-1:0]  c_eff;
	logic [RW-1:0]  r_eff;
	logic           accept;

	logic           v_s1;
	logic [PW-1:0]  px_s1;
	logic [CW-1:0]  col_s1;
	logic [RW-1:0]  row_s1;
	logic           lc_s1;
	logic           lr_s1;
	logic           move_s1;

	logic [2*PW-1:0]   lb_rd;
	logic [2*PW-1:0]   lb_wr;
	s3f_pkg::win_t     win_q;
	s3f_pkg::win_t     nw;
	logic              r1;
	logic              r2;
	logic              c1;
	logic              c2;
	logic [3:0]        mask;
	s3f_pkg::desc_t    desc [4];
	logic [s3f_pkg::COORD_W-1:0] row_up;
	logic [s3f_pkg::COORD_W-1:0] row_here;
	logic [s3f_pkg::COORD_W-1:0] col_left;
	logic [s3f_pkg::COORD_W-1:0] col_here;

	logic [3:0]        mask_s2;
	s3f_pkg::desc_t    desc_s2 [4];
	logic [1:0]        sel;
	logic [3:0]        rest;
	logic              pop;
	logic              free_s2;
	logic              mac_ready;
	s3f_pkg::job_t     job;
	s3f_pkg::res_t     res;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= s3f_pkg::WIDTH_RST;
			height_q <= s3f_pkg::HEIGHT_RST;
			center_q <= s3f_pkg::CENTER_RST;
			edge_q   <= s3f_pkg::EDGE_RST;
			corner_q <= s3f_pkg::CORNER_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				s3f_pkg::REG_IMAGE_WIDTH:   width_q  <= cfg_data[s3f_pkg::SIZE_W-1:0];
				s3f_pkg::REG_IMAGE_HEIGHT:  height_q <= cfg_data[s3f_pkg::SIZE_W-1:0];
				s3f_pkg::REG_CENTER_WEIGHT: center_q <= $signed(cfg_data);
				s3f_pkg::REG_EDGE_WEIGHT:   edge_q   <= $signed(cfg_data);
				s3f_pkg::REG_CORNER_WEIGHT: corner_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// frame size, clamped
	always_comb begin
		w_ext = WXW'(width_q);
		h_ext = HXW'(height_q);
		if (w_ext == '0) begin
			w_eff = WXW'(1);
		end else if (w_ext > WXW'(MAX_WIDTH)) begin
			w_eff = WXW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (h_ext == '0) begin
			h_eff = HXW'(1);
		end else if (h_ext > HXW'(MAX_HEIGHT)) begin
			h_eff = HXW'(MAX_HEIGHT);
		end else begin
			h_eff = h_ext;
		end
		w_last = CW'(w_eff - WXW'(1));
		h_last = RW'(h_eff - HXW'(1));
	end

	// position of the incoming pixel
	assign last_col = (col_q >= w_last);
	assign last_row = (row_q >= h_last);
	assign c_eff    = last_col ? w_last : col_q;
	assign r_eff    = last_row ? h_last : row_q;

	assign move_s1  = v_s1 && free_s2;
	assign s_tready = !v_s1 || move_s1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : r_eff + RW'(1);
				end else begin
					col_q <= c_eff + CW'(1);
					row_q <= r_eff;
				end
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (move_s1) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1  <= s_tdata;
			col_s1 <= c_eff;
			row_s1 <= r_eff;
			lc_s1  <= last_col;
			lr_s1  <= last_row;
		end
	end

	// two previous rows: older in the upper byte, newer in the lower
	assign lb_wr = {lb_rd[PW-1:0], px_s1};

	s3f_linebuf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW),
		.DW    (2 * PW)
	) u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (c_eff),
		.rd_data (lb_rd),
		.wr_en   (move_s1),
		.wr_addr (col_s1),
		.wr_data (lb_wr)
	);

	// window shifted by the new column
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nw[i][0] = win_q[i][1];
			nw[i][1] = win_q[i][2];
		end
		nw[0][2] = lb_rd[2*PW-1:PW];
		nw[1][2] = lb_rd[PW-1:0];
		nw[2][2] = px_s1;
	end

	assign r1 = (row_s1 != '0);
	assign r2 = (row_s1 >= RW'(2));
	assign c1 = (col_s1 != '0);
	assign c2 = (col_s1 >= CW'(2));

	assign row_up   = s3f_pkg::COORD_W'(row_s1 - RW'(1));
	assign row_here = s3f_pkg::COORD_W'(row_s1);
	assign col_left = s3f_pkg::COORD_W'(col_s1 - CW'(1));
	assign col_here = s3f_pkg::COORD_W'(col_s1);

	// results in emission order: above-left, above, left, here
	always_comb begin
		mask[0] = r1 && c1;
		mask[1] = r1 && lc_s1;
		mask[2] = lr_s1 && c1;
		mask[3] = lr_s1 && lc_s1;
		desc[0].sums = s3f_pkg::win_sums(nw, 1, 1, r2, 1'b1, c2, 1'b1);
		desc[0].row  = row_up;
		desc[0].col  = col_left;
		desc[0].eof  = 1'b0;
		desc[1].sums = s3f_pkg::win_sums(nw, 1, 2, r2, 1'b1, c1, 1'b0);
		desc[1].row  = row_up;
		desc[1].col  = col_here;
		desc[1].eof  = 1'b0;
		desc[2].sums = s3f_pkg::win_sums(nw, 2, 1, r1, 1'b0, c2, 1'b1);
		desc[2].row  = row_here;
		desc[2].col  = col_left;
		desc[2].eof  = 1'b0;
		desc[3].sums = s3f_pkg::win_sums(nw, 2, 2, r1, 1'b0, c1, 1'b0);
		desc[3].row  = row_here;
		desc[3].col  = col_here;
		desc[3].eof  = 1'b1;
	end

	// pending results of one pixel, handed out lowest first
	always_comb begin
		sel = 2'd0;
		for (int i = 3; i >= 0; i--) begin
			if (mask_s2[i]) begin
				sel = 2'(i);
			end
		end
	end

	assign rest      = mask_s2 & (mask_s2 - 4'd1);
	assign pop       = (mask_s2 != '0) && mac_ready;
	assign free_s2   = (mask_s2 == '0) || (pop && rest == '0);
	assign job.desc  = desc_s2[sel];
	assign job.last  = (rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			mask_s2 <= '0;
		end else begin
			if (move_s1) begin
				win_q   <= nw;
				mask_s2 <= mask;
			end else if (pop) begin
				mask_s2 <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			for (int i = 0; i < 4; i++) begin
				desc_s2[i] <= desc[i];
			end
		end
	end

	s3f_mac u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (mask_s2 != '0),
		.in_ready      (mac_ready),
		.in_job        (job),
		.center_weight (center_q),
		.edge_weight   (edge_q),
		.corner_weight (corner_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_res       (res)
	);

	assign m_tdata = {4'd0, res.col, res.row, res.value};
	assign m_tlast = res.last;
	assign m_tuser = res.eof;

endmodule

[sv/s3f_port_checker.sv]
`include "symmetric_3x3_filter_core_defines.svh"

module s3f_port_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [s3f_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast,
	input logic                           m_tuser
);

	// next beat opens a frame
	logic after_eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_eof_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			after_eof_q <= m_tuser;
		end
	end

	`S3F_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`S3F_ASSERT_NEXT(a_data_hold, m_tvalid && !m_tready, $stable({m_tdata, m_tlast, m_tuser}))
	`S3F_ASSERT(a_eof_last, m_tvalid && m_tuser, m_tlast)
	`S3F_ASSERT(a_frame_origin, m_tvalid && m_tready && after_eof_q, m_tdata[33:24] == 10'd0)

endmodule

bind symmetric_3x3_filter_core s3f_port_checker u_port_checker (.*);
